// ----- hw/rtl/segmented_array_machine_core_top_assert.svh -----
// Assertion macros for the segmented array machine core.
// Used by modules that carry concurrent checks; needs no other file.
`ifndef SEGMENTED_ARRAY_MACHINE_CORE_TOP_ASSERT_SVH
`define SEGMENTED_ARRAY_MACHINE_CORE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SAM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sam assertion failed");
`define SAM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sam assertion failed");
`else
`define SAM_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SAM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/sam_pkg.sv -----
// Shared types and codes of the segmented array machine core.
// No dependencies; used by the interfaces and the core top module.
package sam_pkg;

   localparam int ARRAY_SLOTS_DEF = 64;
   localparam int SLOT_WORDS_DEF  = 4096;

   localparam logic [1:0] OPR_CLEAR  = 2'd0;
   localparam logic [1:0] OPR_APPEND = 2'd1;
   localparam logic [1:0] OPR_EXEC   = 2'd2;

   localparam logic [3:0] OP_CMOV  = 4'd0;
   localparam logic [3:0] OP_AREAD = 4'd1;
   localparam logic [3:0] OP_AWRT  = 4'd2;
   localparam logic [3:0] OP_ADD   = 4'd3;
   localparam logic [3:0] OP_MUL   = 4'd4;
   localparam logic [3:0] OP_DIV   = 4'd5;
   localparam logic [3:0] OP_NAND  = 4'd6;
   localparam logic [3:0] OP_HALT  = 4'd7;
   localparam logic [3:0] OP_ALLOC = 4'd8;
   localparam logic [3:0] OP_FREE  = 4'd9;
   localparam logic [3:0] OP_OUT   = 4'd10;
   localparam logic [3:0] OP_IN    = 4'd11;
   localparam logic [3:0] OP_LOADP = 4'd12;
   localparam logic [3:0] OP_LDI   = 4'd13;

   localparam logic [3:0] FLT_NONE      = 4'd0;
   localparam logic [3:0] FLT_PC        = 4'd1;
   localparam logic [3:0] FLT_INACTIVE  = 4'd2;
   localparam logic [3:0] FLT_INDEX     = 4'd3;
   localparam logic [3:0] FLT_DIVZERO   = 4'd4;
   localparam logic [3:0] FLT_FREEZERO  = 4'd5;
   localparam logic [3:0] FLT_FREEINACT = 4'd6;
   localparam logic [3:0] FLT_OUTRANGE  = 4'd7;
   localparam logic [3:0] FLT_OPCODE    = 4'd8;
   localparam logic [3:0] FLT_NOMEM     = 4'd9;
   localparam logic [3:0] FLT_TOOLONG   = 4'd10;

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_RDB, S_RDC, S_RDA, S_EXEC, S_LEN, S_MEMRD,
      S_FSTK, S_FILL, S_DIV, S_COPY_RD, S_COPY_WR, S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] program_word;
      logic [7:0]  input_byte;
      logic        input_eof;
   } req_payload_type;

   typedef struct packed {
      logic        out_valid;
      logic [7:0]  out_byte;
      logic        input_taken;
      logic        halted;
      logic [3:0]  fault;
      logic [31:0] program_counter;
   } rsp_payload_type;

endpackage

// ----- hw/rtl/sam_req_if.sv -----
// Request channel of the segmented array machine core.
// Depends on sam_pkg for the payload type.
interface sam_req_if;
   logic                      valid;
   logic                      ready;
   sam_pkg::req_payload_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sam_rsp_if.sv -----
// Response channel of the segmented array machine core.
// Depends on sam_pkg for the payload type.
interface sam_rsp_if;
   logic                      valid;
   logic                      ready;
   sam_pkg::rsp_payload_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/segmented_array_machine_core_top.sv -----
// Segmented array machine core: one item at a time; an item occupies the core until its
// response is registered, longer while the result waits. Clear, append and idle execute go
// straight to the response; an instruction is fetched, its registers are read, and array
// access, divide, allocate and load program take further steps on one shared word memory.
// Synchronous reset clears registers, lengths, active ids, counters, pc, halt and fault at
// once through valid bits; the word memory and free-id stack are not cleared.
module segmented_array_machine_core_top #(
   parameter int ARRAY_SLOTS = sam_pkg::ARRAY_SLOTS_DEF,
   parameter int SLOT_WORDS  = sam_pkg::SLOT_WORDS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sam_req_if.sink   req_if,
   sam_rsp_if.source rsp_if
);
   `include "segmented_array_machine_core_top_assert.svh"

   localparam int ID_W        = $clog2(ARRAY_SLOTS);
   localparam int CNT_W       = $clog2(ARRAY_SLOTS + 1);
   localparam int LEN_W       = $clog2(SLOT_WORDS + 1);
   localparam int STORE_DEPTH = ARRAY_SLOTS * SLOT_WORDS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   function automatic logic [ADDR_W-1:0] st_addr(input logic [ID_W-1:0] id,
                                                 input logic [LEN_W-1:0] off);
      st_addr = ADDR_W'(id) * ADDR_W'(SLOT_WORDS) + ADDR_W'(off);
   endfunction

   sam_pkg::state_type state_ff, state_in;

   logic [31:0]            pc_ff, pc_in;
   logic                   halt_ff, halt_in;
   logic [3:0]             fault_ff, fault_in;
   logic [LEN_W-1:0]       len0_ff, len0_in;
   logic [CNT_W-1:0]       free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]       fresh_ff, fresh_in;
   logic [7:0]             reg_vld_ff, reg_vld_in;
   logic [ARRAY_SLOTS-1:0] len_vld_ff, len_vld_in;
   logic [ARRAY_SLOTS-1:0] active_ff, active_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   sam_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [31:0]      instr_ff, instr_in;
   logic [31:0]      ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in;
   logic [7:0]       byte_ff, byte_in;
   logic             eof_ff, eof_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [LEN_W-1:0] n_ff, n_in, cnt_ff, cnt_in;
   logic             ov_ff, ov_in, it_ff, it_in;
   logic [7:0]       ob_ff, ob_in;
   logic [2:0]       reg_raddr_ff;
   logic [ID_W-1:0]  len_raddr_ff;

   // memory ports
   logic              st_we;
   logic [ADDR_W-1:0] st_waddr, st_raddr;
   logic [31:0]       st_wdata, st_rdata;
   logic              reg_we;
   logic [2:0]        reg_waddr, reg_raddr;
   logic [31:0]       reg_wdata, reg_rdata, reg_rval;
   logic              len_we;
   logic [ID_W-1:0]   len_waddr, len_raddr;
   logic [LEN_W-1:0]  len_wdata, len_rdata, len_rval, len_use;
   logic              fs_we;
   logic [ID_W-1:0]   fs_waddr, fs_raddr, fs_rdata;
   logic              div_start, div_done;
   logic [31:0]       div_q;

   logic        acc;
   logic [3:0]  opc;
   logic        ok_a, ok_b, ok_c;
   logic        pc_bad, exec_go, fill_end, copy_end, rsp_free;

   sam_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .raddr(st_raddr), .rdata(st_rdata));
   sam_ram #(.WIDTH(32), .DEPTH(8)) u_regs (
      .clock(clock), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
      .raddr(reg_raddr), .rdata(reg_rdata));
   sam_ram #(.WIDTH(LEN_W), .DEPTH(ARRAY_SLOTS)) u_lens (
      .clock(clock), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
      .raddr(len_raddr), .rdata(len_rdata));
   sam_ram #(.WIDTH(ID_W), .DEPTH(ARRAY_SLOTS)) u_free (
      .clock(clock), .we(fs_we), .waddr(fs_waddr), .wdata(rc_ff[ID_W-1:0]),
      .raddr(fs_raddr), .rdata(fs_rdata));
   sam_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(rb_ff),
      .divisor(rc_ff), .done(div_done), .quotient(div_q));

   assign acc      = req_if.valid && req_if.ready;
   assign opc      = instr_ff[31:28];
   assign reg_rval = reg_vld_ff[reg_raddr_ff] ? reg_rdata : '0;
   assign len_rval = len_vld_ff[len_raddr_ff] ? len_rdata : '0;
   assign len_use  = (id_ff == '0) ? len0_ff : len_rval;
   assign ok_a     = ra_ff < 32'(ARRAY_SLOTS) && active_ff[ra_ff[ID_W-1:0]];
   assign ok_b     = rb_ff < 32'(ARRAY_SLOTS) && active_ff[rb_ff[ID_W-1:0]];
   assign ok_c     = rc_ff < 32'(ARRAY_SLOTS) && active_ff[rc_ff[ID_W-1:0]];
   assign pc_bad   = pc_ff >= 32'(len0_ff);
   assign exec_go  = req_if.data.operation == sam_pkg::OPR_EXEC && !halt_ff && !pc_bad;
   assign fill_end = cnt_ff >= n_ff;
   assign copy_end = cnt_ff + LEN_W'(1) >= n_ff;
   assign rsp_free = !rsp_vld_ff || rsp_if.ready;

   assign req_if.ready = state_ff == sam_pkg::S_IDLE;
   assign rsp_if.valid = rsp_vld_ff;
   assign rsp_if.data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sam_pkg::S_IDLE: begin
            if (acc) begin
               state_in = exec_go ? sam_pkg::S_FETCH : sam_pkg::S_RESP;
            end
         end
         sam_pkg::S_FETCH: state_in = sam_pkg::S_RDB;
         sam_pkg::S_RDB:   state_in = sam_pkg::S_RDC;
         sam_pkg::S_RDC:   state_in = sam_pkg::S_RDA;
         sam_pkg::S_RDA:   state_in = sam_pkg::S_EXEC;
         sam_pkg::S_EXEC: begin
            state_in = sam_pkg::S_RESP;
            if (opc == sam_pkg::OP_AREAD && ok_b) begin
               state_in = sam_pkg::S_LEN;
            end else if (opc == sam_pkg::OP_AWRT && ok_a) begin
               state_in = sam_pkg::S_LEN;
            end else if (opc == sam_pkg::OP_DIV && rc_ff != '0) begin
               state_in = sam_pkg::S_DIV;
            end else if (opc == sam_pkg::OP_LOADP && rb_ff != '0 && ok_b) begin
               state_in = sam_pkg::S_LEN;
            end else if (opc == sam_pkg::OP_ALLOC && rc_ff <= 32'(SLOT_WORDS)) begin
               if (free_cnt_ff != '0) begin
                  state_in = sam_pkg::S_FSTK;
               end else if (fresh_ff < CNT_W'(ARRAY_SLOTS)) begin
                  state_in = sam_pkg::S_FILL;
               end
            end
         end
         sam_pkg::S_LEN: begin
            state_in = sam_pkg::S_RESP;
            if (opc == sam_pkg::OP_AREAD && rc_ff < 32'(len_use)) begin
               state_in = sam_pkg::S_MEMRD;
            end else if (opc == sam_pkg::OP_LOADP && len_use != '0) begin
               state_in = sam_pkg::S_COPY_RD;
            end
         end
         sam_pkg::S_MEMRD: state_in = sam_pkg::S_RESP;
         sam_pkg::S_FSTK:  state_in = sam_pkg::S_FILL;
         sam_pkg::S_FILL: begin
            if (fill_end) state_in = sam_pkg::S_RESP;
         end
         sam_pkg::S_DIV: begin
            if (div_done) state_in = sam_pkg::S_RESP;
         end
         sam_pkg::S_COPY_RD: state_in = sam_pkg::S_COPY_WR;
         sam_pkg::S_COPY_WR: begin
            state_in = copy_end ? sam_pkg::S_RESP : sam_pkg::S_COPY_RD;
         end
         sam_pkg::S_RESP: begin
            if (rsp_free) state_in = sam_pkg::S_IDLE;
         end
         default: state_in = sam_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      pc_in       = pc_ff;
      halt_in     = halt_ff;
      fault_in    = fault_ff;
      len0_in     = len0_ff;
      free_cnt_in = free_cnt_ff;
      fresh_in    = fresh_ff;
      reg_vld_in  = reg_vld_ff;
      len_vld_in  = len_vld_ff;
      active_in   = active_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_if.ready;
      rsp_data_in = rsp_data_ff;
      instr_in    = instr_ff;
      ra_in       = ra_ff;
      rb_in       = rb_ff;
      rc_in       = rc_ff;
      byte_in     = byte_ff;
      eof_in      = eof_ff;
      id_in       = id_ff;
      n_in        = n_ff;
      cnt_in      = cnt_ff;
      ov_in       = ov_ff;
      ob_in       = ob_ff;
      it_in       = it_ff;
      st_we       = 1'b0;
      st_waddr    = '0;
      st_wdata    = '0;
      st_raddr    = '0;
      reg_we      = 1'b0;
      reg_waddr   = '0;
      reg_wdata   = '0;
      reg_raddr   = '0;
      len_we      = 1'b0;
      len_waddr   = id_ff;
      len_wdata   = n_ff;
      len_raddr   = '0;
      fs_we       = 1'b0;
      fs_waddr    = free_cnt_ff[ID_W-1:0];
      fs_raddr    = '0;
      div_start   = 1'b0;

      unique case (state_ff)
         sam_pkg::S_IDLE: begin
            if (acc) begin
               ov_in   = 1'b0;
               ob_in   = '0;
               it_in   = 1'b0;
               byte_in = req_if.data.input_byte;
               eof_in  = req_if.data.input_eof;
               priority if (req_if.data.operation == sam_pkg::OPR_CLEAR) begin
                  pc_in       = '0;
                  halt_in     = 1'b0;
                  fault_in    = sam_pkg::FLT_NONE;
                  len0_in     = '0;
                  free_cnt_in = '0;
                  fresh_in    = CNT_W'(1);
                  reg_vld_in  = '0;
                  len_vld_in  = '0;
                  active_in   = ARRAY_SLOTS'(1);
               end else if (req_if.data.operation == sam_pkg::OPR_APPEND) begin
                  if (fault_ff == sam_pkg::FLT_NONE) begin
                     if (len0_ff >= LEN_W'(SLOT_WORDS)) begin
                        fault_in = sam_pkg::FLT_TOOLONG;
                        halt_in  = 1'b1;
                     end else begin
                        st_we    = 1'b1;
                        st_waddr = st_addr('0, len0_ff);
                        st_wdata = req_if.data.program_word;
                        len0_in  = len0_ff + LEN_W'(1);
                     end
                  end
               end else if (req_if.data.operation == sam_pkg::OPR_EXEC && !halt_ff) begin
                  if (pc_bad) begin
                     fault_in = sam_pkg::FLT_PC;
                     halt_in  = 1'b1;
                  end else begin
                     st_raddr = st_addr('0, pc_ff[LEN_W-1:0]);
                  end
               end else begin
                  // unused operation or execute while halted: report state only
                  halt_in = halt_ff;
               end
            end
         end
         sam_pkg::S_FETCH: begin
            instr_in  = st_rdata;
            reg_raddr = st_rdata[5:3];
         end
         sam_pkg::S_RDB: begin
            rb_in     = reg_rval;
            reg_raddr = instr_ff[2:0];
         end
         sam_pkg::S_RDC: begin
            rc_in     = reg_rval;
            reg_raddr = instr_ff[8:6];
         end
         sam_pkg::S_RDA: begin
            ra_in = reg_rval;
         end
         sam_pkg::S_EXEC: begin
            reg_waddr = instr_ff[8:6];
            unique case (opc)
               sam_pkg::OP_CMOV: begin
                  reg_we    = rc_ff != '0;
                  reg_wdata = rb_ff;
                  pc_in     = pc_ff + 32'd1;
               end
               sam_pkg::OP_AREAD: begin
                  if (!ok_b) begin
                     fault_in = sam_pkg::FLT_INACTIVE;
                     halt_in  = 1'b1;
                  end else begin
                     id_in     = rb_ff[ID_W-1:0];
                     len_raddr = rb_ff[ID_W-1:0];
                  end
               end
               sam_pkg::OP_AWRT: begin
                  if (!ok_a) begin
                     fault_in = sam_pkg::FLT_INACTIVE;
                     halt_in  = 1'b1;
                  end else begin
                     id_in     = ra_ff[ID_W-1:0];
                     len_raddr = ra_ff[ID_W-1:0];
                  end
               end
               sam_pkg::OP_ADD: begin
                  reg_we    = 1'b1;
                  reg_wdata = rb_ff + rc_ff;
                  pc_in     = pc_ff + 32'd1;
               end
               sam_pkg::OP_MUL: begin
                  reg_we    = 1'b1;
                  reg_wdata = rb_ff * rc_ff;
                  pc_in     = pc_ff + 32'd1;
               end
               sam_pkg::OP_DIV: begin
                  if (rc_ff == '0) begin
                     fault_in = sam_pkg::FLT_DIVZERO;
                     halt_in  = 1'b1;
                  end else begin
                     div_start = 1'b1;
                  end
               end
               sam_pkg::OP_NAND: begin
                  reg_we    = 1'b1;
                  reg_wdata = ~(rb_ff & rc_ff);
                  pc_in     = pc_ff + 32'd1;
               end
               sam_pkg::OP_HALT: begin
                  halt_in = 1'b1;
                  pc_in   = pc_ff + 32'd1;
               end
               sam_pkg::OP_ALLOC: begin
                  n_in   = rc_ff[LEN_W-1:0];
                  cnt_in = '0;
                  if (rc_ff > 32'(SLOT_WORDS)) begin
                     fault_in = sam_pkg::FLT_NOMEM;
                     halt_in  = 1'b1;
                  end else if (free_cnt_ff != '0) begin
                     free_cnt_in = free_cnt_ff - CNT_W'(1);
                     fs_raddr    = free_cnt_in[ID_W-1:0];
                  end else if (fresh_ff < CNT_W'(ARRAY_SLOTS)) begin
                     id_in    = fresh_ff[ID_W-1:0];
                     fresh_in = fresh_ff + CNT_W'(1);
                  end else begin
                     fault_in = sam_pkg::FLT_NOMEM;
                     halt_in  = 1'b1;
                  end
               end
               sam_pkg::OP_FREE: begin
                  if (rc_ff == '0) begin
                     fault_in = sam_pkg::FLT_FREEZERO;
                     halt_in  = 1'b1;
                  end else if (!ok_c) begin
                     fault_in = sam_pkg::FLT_FREEINACT;
                     halt_in  = 1'b1;
                  end else begin
                     active_in[rc_ff[ID_W-1:0]]  = 1'b0;
                     len_vld_in[rc_ff[ID_W-1:0]] = 1'b0;
                     id_in = rc_ff[ID_W-1:0];
                     pc_in = pc_ff + 32'd1;
                  end
               end
               sam_pkg::OP_OUT: begin
                  if (rc_ff[31:8] != '0) begin
                     fault_in = sam_pkg::FLT_OUTRANGE;
                     halt_in  = 1'b1;
                  end else begin
                     ov_in = 1'b1;
                     ob_in = rc_ff[7:0];
                     pc_in = pc_ff + 32'd1;
                  end
               end
               sam_pkg::OP_IN: begin
                  reg_we    = 1'b1;
                  reg_waddr = instr_ff[2:0];
                  reg_wdata = eof_ff ? '1 : 32'(byte_ff);
                  it_in     = 1'b1;
                  pc_in     = pc_ff + 32'd1;
               end
               sam_pkg::OP_LOADP: begin
                  if (rb_ff == '0) begin
                     pc_in = rc_ff;
                  end else if (!ok_b) begin
                     fault_in = sam_pkg::FLT_INACTIVE;
                     halt_in  = 1'b1;
                  end else begin
                     id_in     = rb_ff[ID_W-1:0];
                     len_raddr = rb_ff[ID_W-1:0];
                  end
               end
               sam_pkg::OP_LDI: begin
                  reg_we    = 1'b1;
                  reg_waddr = instr_ff[27:25];
                  reg_wdata = {7'd0, instr_ff[24:0]};
                  pc_in     = pc_ff + 32'd1;
               end
               default: begin
                  fault_in = sam_pkg::FLT_OPCODE;
                  halt_in  = 1'b1;
               end
            endcase
         end
         sam_pkg::S_LEN: begin
            n_in   = len_use;
            cnt_in = '0;
            if (opc == sam_pkg::OP_AREAD) begin
               if (rc_ff >= 32'(len_use)) begin
                  fault_in = sam_pkg::FLT_INDEX;
                  halt_in  = 1'b1;
               end else begin
                  st_raddr = st_addr(id_ff, rc_ff[LEN_W-1:0]);
               end
            end else if (opc == sam_pkg::OP_AWRT) begin
               if (rb_ff >= 32'(len_use)) begin
                  fault_in = sam_pkg::FLT_INDEX;
                  halt_in  = 1'b1;
               end else begin
                  st_we    = 1'b1;
                  st_waddr = st_addr(id_ff, rb_ff[LEN_W-1:0]);
                  st_wdata = rc_ff;
                  pc_in    = pc_ff + 32'd1;
               end
            end else if (len_use == '0) begin
               // empty source: array 0 becomes empty and pc jumps
               len0_in = '0;
               pc_in   = rc_ff;
            end
         end
         sam_pkg::S_MEMRD: begin
            reg_we    = 1'b1;
            reg_waddr = instr_ff[8:6];
            reg_wdata = st_rdata;
            pc_in     = pc_ff + 32'd1;
         end
         sam_pkg::S_FSTK: begin
            id_in = fs_rdata;
         end
         sam_pkg::S_FILL: begin
            if (!fill_end) begin
               st_we    = 1'b1;
               st_waddr = st_addr(id_ff, cnt_ff);
               cnt_in   = cnt_ff + LEN_W'(1);
            end else begin
               len_we              = 1'b1;
               len_vld_in[id_ff]   = 1'b1;
               active_in[id_ff]    = 1'b1;
               reg_we              = 1'b1;
               reg_waddr           = instr_ff[5:3];
               reg_wdata           = 32'(id_ff);
               pc_in               = pc_ff + 32'd1;
            end
         end
         sam_pkg::S_DIV: begin
            if (div_done) begin
               reg_we    = 1'b1;
               reg_waddr = instr_ff[8:6];
               reg_wdata = div_q;
               pc_in     = pc_ff + 32'd1;
            end
         end
         sam_pkg::S_COPY_RD: begin
            st_raddr = st_addr(id_ff, cnt_ff);
         end
         sam_pkg::S_COPY_WR: begin
            st_we    = 1'b1;
            st_waddr = st_addr('0, cnt_ff);
            st_wdata = st_rdata;
            cnt_in   = cnt_ff + LEN_W'(1);
            if (copy_end) begin
               len0_in = n_ff;
               pc_in   = rc_ff;
            end
         end
         sam_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_vld_in                  = 1'b1;
               rsp_data_in.out_valid       = ov_ff;
               rsp_data_in.out_byte        = ob_ff;
               rsp_data_in.input_taken     = it_ff;
               rsp_data_in.halted          = halt_ff;
               rsp_data_in.fault           = fault_ff;
               rsp_data_in.program_counter = pc_ff;
            end
         end
         default: begin
            rsp_vld_in = rsp_vld_ff && !rsp_if.ready;
         end
      endcase

      // push a freed id when the stack has room
      if (state_ff == sam_pkg::S_EXEC && opc == sam_pkg::OP_FREE && rc_ff != '0 && ok_c &&
          free_cnt_ff < CNT_W'(ARRAY_SLOTS)) begin
         fs_we       = 1'b1;
         free_cnt_in = free_cnt_ff + CNT_W'(1);
      end
      if (reg_we) begin
         reg_vld_in[reg_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sam_pkg::S_IDLE;
         pc_ff       <= '0;
         halt_ff     <= 1'b0;
         fault_ff    <= sam_pkg::FLT_NONE;
         len0_ff     <= '0;
         free_cnt_ff <= '0;
         fresh_ff    <= CNT_W'(1);
         reg_vld_ff  <= '0;
         len_vld_ff  <= '0;
         active_ff   <= ARRAY_SLOTS'(1);
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pc_ff       <= pc_in;
         halt_ff     <= halt_in;
         fault_ff    <= fault_in;
         len0_ff     <= len0_in;
         free_cnt_ff <= free_cnt_in;
         fresh_ff    <= fresh_in;
         reg_vld_ff  <= reg_vld_in;
         len_vld_ff  <= len_vld_in;
         active_ff   <= active_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      rsp_data_ff  <= rsp_data_in;
      instr_ff     <= instr_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      rc_ff        <= rc_in;
      byte_ff      <= byte_in;
      eof_ff       <= eof_in;
      id_ff        <= id_in;
      n_ff         <= n_in;
      cnt_ff       <= cnt_in;
      ov_ff        <= ov_in;
      ob_ff        <= ob_in;
      it_ff        <= it_in;
      reg_raddr_ff <= reg_raddr;
      len_raddr_ff <= len_raddr;
   end

   `SAM_ASSERT_IMPL(a_fault_halts, clock, reset, fault_ff != sam_pkg::FLT_NONE, halt_ff)
   `SAM_ASSERT_IMPL(a_free_bound, clock, reset, 1'b1, free_cnt_ff <= CNT_W'(ARRAY_SLOTS))
   `SAM_ASSERT_IMPL(a_prog_bound, clock, reset, 1'b1, len0_ff <= LEN_W'(SLOT_WORDS))
   `SAM_ASSERT_IMPL(a_zero_active, clock, reset, 1'b1, active_ff[0])
   `SAM_ASSERT_NEXT(a_div_ends, clock, reset,
      state_ff == sam_pkg::S_DIV && div_done, state_ff == sam_pkg::S_RESP)
endmodule

// ----- hw/rtl/sam_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sam_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- hw/rtl/sam_div.sv -----
// Bit-serial unsigned 32-bit divider, one quotient bit per cycle.
// No dependencies; divisor must be nonzero when started.
module sam_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [32:0] shifted;
   logic [32:0] trial;

   assign shifted = {rem_ff, quot_ff[31]};
   assign trial   = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd32;
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff && cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         if (!trial[32]) begin
            rem_in  = trial[31:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = shifted[31:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = busy_ff && cnt_ff == 6'd0;
   assign quotient = quot_ff;
endmodule
